// ===== design/kbf_pkg.sv =====
// ----------------------------------------------------------------------------
// kbf_pkg
// Shared types and constants of the k-mer Bloom filter.
// ----------------------------------------------------------------------------
`default_nettype none

package kbf_pkg;

   localparam int              HASH_W              = 32;
   localparam int              K_MAX_DEFAULT       = 32;
   localparam longint unsigned BLOOM_BITS_DEFAULT  = 64'd1048576;
   localparam longint unsigned RUN_MAX_DEFAULT     = 64'd65535;

   localparam logic [5:0]      KMER_LENGTH_RESET   = 6'd31;
   localparam logic [15:0]     KMER_INDEX_MAX      = 16'hFFFF;

   localparam logic            MODE_INSERT         = 1'b0;
   localparam logic            MODE_QUERY          = 1'b1;

   // Item that travels down the pipeline beside the hash.
   typedef struct packed {
      logic        valid;
      logic        mode;
      logic        group_end;
      logic [15:0] kmer_index;
   } tag_type;

endpackage

`default_nettype wire

// ===== design/kbf_hash_cell.sv =====
// ----------------------------------------------------------------------------
// kbf_hash_cell
// One xorshift32 step of the window hash chain. The cell holds the hash of
// the window that is one character longer than its left neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module kbf_hash_cell (
   input  wire logic                         clock,
   input  wire logic                         enable,
   input  wire logic [7:0]                   base,
   input  wire logic [kbf_pkg::HASH_W-1:0]   prev_hash,
   output logic      [kbf_pkg::HASH_W-1:0]   hash
);

   localparam int SHIFT_A = 13;
   localparam int SHIFT_B = 17;
   localparam int SHIFT_C = 5;

   logic [kbf_pkg::HASH_W-1:0] hash_ff;
   logic [kbf_pkg::HASH_W-1:0] hash_in;
   logic [kbf_pkg::HASH_W-1:0] mix_a;
   logic [kbf_pkg::HASH_W-1:0] mix_b;
   logic [kbf_pkg::HASH_W-1:0] mix_c;

   always_comb begin
      // base is hashed as a signed char
      mix_a   = prev_hash ^ {{(kbf_pkg::HASH_W-8){base[7]}}, base};
      mix_b   = mix_a ^ (mix_a << SHIFT_A);
      mix_c   = mix_b ^ (mix_b >> SHIFT_B);
      hash_in = mix_c ^ (mix_c << SHIFT_C);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hash_ff <= hash_in;
      end
   end

   assign hash = hash_ff;

endmodule

`default_nettype wire

// ===== design/kbf_index_unit.sv =====
// ----------------------------------------------------------------------------
// kbf_index_unit
// Reduces the 32-bit hash modulo the filter size in four stages: multiply
// by a fixed reciprocal, multiply the quotient back, subtract, correct.
// ----------------------------------------------------------------------------
`default_nettype none

module kbf_index_unit #(
   parameter longint unsigned BLOOM_BITS = kbf_pkg::BLOOM_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire kbf_pkg::tag_type             in_tag,
   input  wire logic [kbf_pkg::HASH_W-1:0]   in_hash,
   output kbf_pkg::tag_type                  out_tag,
   output logic      [kbf_pkg::HASH_W-1:0]   out_bit_index
);

   localparam int           HW         = kbf_pkg::HASH_W;
   localparam int           IDX_BITS   = $clog2(BLOOM_BITS);
   localparam int           SHIFT      = HW + IDX_BITS;
   // floor(2^(32+L) / B) stays below 2^33; the estimated quotient is off by at most one
   localparam logic [64:0]  RECIP_WIDE = (65'd1 << SHIFT) / 65'(BLOOM_BITS);
   localparam logic [32:0]  RECIP      = RECIP_WIDE[32:0];
   localparam logic [33:0]  DIVISOR    = 34'(BLOOM_BITS);

   kbf_pkg::tag_type  a_tag_ff, b_tag_ff, c_tag_ff, d_tag_ff;
   logic [HW-1:0]     a_hash_ff, b_hash_ff;
   logic [64:0]       a_prod_ff;
   logic [64:0]       a_prod_in;
   logic [HW-1:0]     b_quot;
   logic [33:0]       b_back_ff;
   logic [33:0]       b_back_in;
   logic [33:0]       c_rem_ff;
   logic [33:0]       c_rem_in;
   logic [33:0]       d_rem_in;
   logic [HW-1:0]     d_index_ff;

   always_comb begin
      a_prod_in = 65'(in_hash) * 65'(RECIP);
      b_quot    = HW'(a_prod_ff >> SHIFT);
      b_back_in = 34'(b_quot) * DIVISOR;
      c_rem_in  = {2'b00, b_hash_ff} - b_back_ff;
      d_rem_in  = (c_rem_ff >= DIVISOR) ? c_rem_ff - DIVISOR : c_rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff <= '0;
         b_tag_ff <= '0;
         c_tag_ff <= '0;
         d_tag_ff <= '0;
      end else if (advance) begin
         a_tag_ff <= in_tag;
         b_tag_ff <= a_tag_ff;
         c_tag_ff <= b_tag_ff;
         d_tag_ff <= c_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_hash_ff  <= in_hash;
         a_prod_ff  <= a_prod_in;
         b_hash_ff  <= a_hash_ff;
         b_back_ff  <= b_back_in;
         c_rem_ff   <= c_rem_in;
         d_index_ff <= d_rem_in[HW-1:0];
      end
   end

   assign out_tag       = d_tag_ff;
   assign out_bit_index = d_index_ff;

endmodule

`default_nettype wire

// ===== design/kbf_filter_mem.sv =====
// ----------------------------------------------------------------------------
// kbf_filter_mem
// Filter bit array in 64-bit rows. Insert sets one bit, query reads a row
// and picks the bit. After reset a sweep clears one row per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kbf_filter_mem #(
   parameter longint unsigned BLOOM_BITS = kbf_pkg::BLOOM_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire kbf_pkg::tag_type             req_tag,
   input  wire logic [kbf_pkg::HASH_W-1:0]   req_bit_index,
   output kbf_pkg::tag_type                  rsp_tag,
   output logic                              rsp_present,
   output logic                              busy
);

   localparam int              ROW_BITS = 64;
   localparam int              COL_W    = $clog2(ROW_BITS);
   localparam longint unsigned ROWS     = (BLOOM_BITS + ROW_BITS - 1) / ROW_BITS;
   localparam int              ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   logic [ROW_BITS-1:0] mem [ROWS];

   logic                clr_active_ff;
   logic [ROW_W-1:0]    clr_row_ff;
   logic [ROW_W-1:0]    row;
   logic [COL_W-1:0]    col;
   logic [ROW_BITS-1:0] rd_row_ff;
   logic [COL_W-1:0]    col_ff;
   kbf_pkg::tag_type    tag_ff;

   assign row = req_bit_index[COL_W +: ROW_W];
   assign col = req_bit_index[COL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_row_ff    <= '0;
      end else if (clr_active_ff) begin
         if (clr_row_ff == LAST_ROW) begin
            clr_active_ff <= 1'b0;
         end else begin
            clr_row_ff <= clr_row_ff + 1'b1;
         end
      end
   end

   // single-bit set: no read-modify-write, so back-to-back items see each other
   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_row_ff] <= '0;
      end else if (advance && req_tag.valid && req_tag.mode == kbf_pkg::MODE_INSERT) begin
         mem[row][col] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rd_row_ff <= mem[row];
         col_ff    <= col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= req_tag;
      end
   end

   assign rsp_tag     = tag_ff;
   assign rsp_present = rd_row_ff[col_ff];
   assign busy        = clr_active_ff;

endmodule

`default_nettype wire

// ===== design/kmer_bloom_filter.sv =====
// ----------------------------------------------------------------------------
// kmer_bloom_filter
// Single-hash Bloom filter over the k-mers of a grouped character stream.
// The block takes one character per cycle while req_stall is low and gives
// at most one query result per character. A row of K_MAX hash cells holds
// the xorshift32 hash of every window length ending at the newest character,
// so the k-mer hash is ready the cycle after the character arrives; a
// four-stage reciprocal unit reduces it modulo BLOOM_BITS and the filter
// memory sets or reads the bit. The whole pipeline holds while a result
// waits on rsp_stall. After reset the filter is cleared one 64-bit row per
// cycle, ceil(BLOOM_BITS/64) rows (16384 at the default size), during which
// req_stall stays high; csr writes are taken at any time. Write csr_kmer_length
// only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_bloom_filter #(
   parameter int              K_MAX      = kbf_pkg::K_MAX_DEFAULT,
   parameter longint unsigned BLOOM_BITS = kbf_pkg::BLOOM_BITS_DEFAULT,
   parameter longint unsigned RUN_MAX    = kbf_pkg::RUN_MAX_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [5:0]  csr_kmer_length,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_base,
   input  wire logic        req_first_of_group,
   input  wire logic        req_last_of_group,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_present,
   output logic [15:0]      rsp_kmer_index,
   output logic             rsp_group_end
);

   localparam int HW      = kbf_pkg::HASH_W;
   localparam int CNT_W   = $clog2(RUN_MAX + 1);
   localparam int DIFF_W  = (CNT_W > 16) ? CNT_W : 16;
   localparam int CELL_IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

   logic                 adv;
   logic                 req_accept;
   logic                 mem_busy;

   logic [5:0]           kmer_length_ff;
   logic [5:0]           kl_nonzero;
   logic [6:0]           k_eff;

   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic [CNT_W-1:0]     cnt_base;
   logic [CNT_W-1:0]     cnt_next;
   logic [DIFF_W-1:0]    kmer_diff;
   logic                 produced;

   logic [HW-1:0]        cell_prev [K_MAX];
   logic [HW-1:0]        cell_hash [K_MAX];

   kbf_pkg::tag_type     s1_tag_in;
   kbf_pkg::tag_type     s1_tag_ff;
   logic [CELL_IW-1:0]   s1_ksel_in;
   logic [CELL_IW-1:0]   s1_ksel_ff;
   kbf_pkg::tag_type     s2_tag_ff;
   logic [HW-1:0]        s2_hash_ff;

   kbf_pkg::tag_type     idx_tag;
   logic [HW-1:0]        idx_bit;
   kbf_pkg::tag_type     mem_tag;
   logic                 mem_present;

   logic                 rsp_valid_ff;
   logic                 rsp_present_ff;
   logic [15:0]          rsp_kmer_index_ff;
   logic                 rsp_group_end_ff;

   assign adv        = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = mem_busy || !adv;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_length_ff <= kbf_pkg::KMER_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         kmer_length_ff <= csr_kmer_length;
      end
   end

   // group count and k-mer position
   always_comb begin
      kl_nonzero = (kmer_length_ff == 6'd0) ? 6'd1 : kmer_length_ff;
      k_eff      = (7'(kl_nonzero) > 7'(K_MAX)) ? 7'(K_MAX) : 7'(kl_nonzero);
      cnt_base   = req_first_of_group ? '0 : cnt_ff;
      cnt_next   = (cnt_base < CNT_W'(RUN_MAX)) ? cnt_base + CNT_W'(1) : cnt_base;
      produced   = DIFF_W'(cnt_next) >= DIFF_W'(k_eff);
      kmer_diff  = DIFF_W'(cnt_next) - DIFF_W'(k_eff);
      cnt_in     = req_last_of_group ? '0 : cnt_next;

      s1_tag_in.valid      = req_accept && produced;
      s1_tag_in.mode       = req_mode;
      s1_tag_in.group_end  = req_last_of_group;
      s1_tag_in.kmer_index = (kmer_diff > DIFF_W'(kbf_pkg::KMER_INDEX_MAX))
                             ? kbf_pkg::KMER_INDEX_MAX : kmer_diff[15:0];
      s1_ksel_in           = CELL_IW'(k_eff - 7'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (req_accept) begin
         cnt_ff <= cnt_in;
      end
   end

   // cell n holds the hash of the last n+1 characters
   for (genvar n = 0; n < K_MAX; n++) begin : g_cell
      if (n == 0) begin : g_head
         assign cell_prev[n] = '0;
      end else begin : g_link
         assign cell_prev[n] = cell_hash[n-1];
      end

      kbf_hash_cell u_cell (
         .clock     (clock),
         .enable    (req_accept),
         .base      (req_base),
         .prev_hash (cell_prev[n]),
         .hash      (cell_hash[n])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
      end else if (adv) begin
         s1_tag_ff <= s1_tag_in;
         s2_tag_ff <= s1_tag_ff;
      end
   end

   // cells advance only on accept, which needs adv: stage one still sees its own window
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ksel_ff <= s1_ksel_in;
         s2_hash_ff <= cell_hash[s1_ksel_ff];
      end
   end

   kbf_index_unit #(
      .BLOOM_BITS (BLOOM_BITS)
   ) u_index (
      .clock         (clock),
      .reset         (reset),
      .advance       (adv),
      .in_tag        (s2_tag_ff),
      .in_hash       (s2_hash_ff),
      .out_tag       (idx_tag),
      .out_bit_index (idx_bit)
   );

   kbf_filter_mem #(
      .BLOOM_BITS (BLOOM_BITS)
   ) u_filter (
      .clock         (clock),
      .reset         (reset),
      .advance       (adv),
      .req_tag       (idx_tag),
      .req_bit_index (idx_bit),
      .rsp_tag       (mem_tag),
      .rsp_present   (mem_present),
      .busy          (mem_busy)
   );

   // inserts drop here; queries load the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= mem_tag.valid && mem_tag.mode == kbf_pkg::MODE_QUERY;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_present_ff    <= mem_present;
         rsp_kmer_index_ff <= mem_tag.kmer_index;
         rsp_group_end_ff  <= mem_tag.group_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_present    = rsp_present_ff;
   assign rsp_kmer_index = rsp_kmer_index_ff;
   assign rsp_group_end  = rsp_group_end_ff;

   a_kmer_enters_pipe : assert property (@(posedge clock) disable iff (reset)
      req_accept && produced |=> s1_tag_ff.valid)
      else $error("completed k-mer did not enter the pipeline");

   a_pipe_holds_on_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(s2_hash_ff) && $stable(s2_tag_ff))
      else $error("pipeline moved while a result was stalled");

   a_clear_after_reset : assert property (@(posedge clock)
      $fell(reset) |-> mem_busy && req_stall)
      else $error("filter clear pass not running after reset");

endmodule

`default_nettype wire
